// ----- src/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define SFR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sfr assertion failed");
// condition must never be true outside reset
`define SFR_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sfr forbidden condition seen");
`else
`define SFR_ASSERT(label, clk, rst_n, prop)
`define SFR_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ----- src/sfr_pkg.sv -----
// package with shared constants and types of the find-and-replace block
package sfr_pkg;

    localparam int MAX_PATTERN_DEF = 8;
    localparam int COUNT_WIDTH_DEF = 16;

    // results of one request never exceed this
    localparam int BURST_DEPTH = 8;
    localparam int BURST_CNT_W = 4;
    localparam int REPL_MAX    = 8;
    localparam int LEN_W       = 4;
    localparam int SHOWN_W     = 16;

    typedef enum logic [1:0] {
        CFG_PATTERN_BYTES = 2'd0,
        CFG_PATTERN_LEN   = 2'd1,
        CFG_REPL_BYTES    = 2'd2,
        CFG_REPL_LEN      = 2'd3
    } cfg_index_t;

    // what one accepted request leaves for the output buffer
    typedef struct packed {
        logic                        hit;
        logic                        bare;
        logic                        stream_end;
        logic [BURST_CNT_W-1:0]      count;
        logic [BURST_DEPTH-1:0][7:0] bytes;
    } burst_load_t;

endpackage

// ----- src/sfr_window.sv -----
// sliding window of held bytes with the match and flush decision
module sfr_window #(
    parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic [7:0]                in_byte,
    input  logic                      stream_end,
    input  logic [63:0]               pattern_bytes,
    input  logic [sfr_pkg::LEN_W-1:0] plen,
    input  logic [63:0]               replacement_bytes,
    input  logic [sfr_pkg::LEN_W-1:0] rlen,
    output sfr_pkg::burst_load_t      load
);

    localparam int FILL_W = $clog2(MAX_PATTERN + 1);

    logic [MAX_PATTERN-1:0][7:0] window_reg;
    logic [MAX_PATTERN-1:0][7:0] window_next;
    logic [FILL_W-1:0]           fill_reg;
    logic [FILL_W-1:0]           fill_next;

    logic [MAX_PATTERN-1:0][7:0] ext;
    logic [FILL_W-1:0]           fill_a;
    logic                        full_old;
    logic                        eq_all;
    logic                        at_len;
    logic                        hit;

    always_comb
    begin
        full_old = (fill_reg == FILL_W'(MAX_PATTERN));
        fill_a   = full_old ? fill_reg : fill_reg + 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            ext[i] = (!full_old && fill_reg == FILL_W'(i)) ? in_byte : window_reg[i];
        end
        eq_all = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (sfr_pkg::LEN_W'(i) < plen && ext[i] != pattern_bytes[8*i +: 8])
            begin
                eq_all = 1'b0;
            end
        end
        at_len = (sfr_pkg::LEN_W'(fill_a) == plen);
        hit    = at_len && eq_all;
    end

    // results and next window for this request
    always_comb
    begin
        load            = '0;
        load.hit        = hit;
        load.stream_end = stream_end;
        window_next     = ext;
        fill_next       = fill_a;
        if (hit)
        begin
            for (int i = 0; i < sfr_pkg::REPL_MAX; i++)
            begin
                load.bytes[i] = replacement_bytes[8*i +: 8];
            end
            fill_next = '0;
            if (stream_end && rlen == '0)
            begin
                load.bare  = 1'b1;
                load.bytes = '0;
                load.count = sfr_pkg::BURST_CNT_W'(1);
            end
            else
            begin
                load.count = sfr_pkg::BURST_CNT_W'(rlen);
            end
        end
        else
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                load.bytes[i] = ext[i];
            end
            if (stream_end)
            begin
                load.count = sfr_pkg::BURST_CNT_W'(fill_a);
                fill_next  = '0;
            end
            else if (sfr_pkg::LEN_W'(fill_a) >= plen)
            begin
                // oldest byte leaves, the rest moves down
                load.count = sfr_pkg::BURST_CNT_W'(1);
                for (int i = 0; i < MAX_PATTERN - 1; i++)
                begin
                    window_next[i] = ext[i + 1];
                end
                fill_next = fill_a - 1'b1;
            end
            else
            begin
                load.count = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (step)
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            window_reg <= window_next;
        end
    end

endmodule

// ----- src/stream_find_and_replace.sv -----
// top level of the streaming find-and-replace block
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  input   | in        | in_valid / in_ready  | in_byte, stream_end
//  output  | out       | out_valid / out_ready| out_byte, byte_valid, run_last,
//          |           |                      | output_end, matches_seen
//  config  | in        | cfg_wr_en            | cfg_index, cfg_data
//
// a request that yields at most one result is taken every cycle while the output
// is not stalled; one that yields more holds in_ready low while the output buffer
// drains, one result per cycle unless out_ready stalls it.
// reset clears the window fill, the match counter and the output buffer; held
// window bytes are not reset, and config resets to pattern length one, rest zero.
// a stalled output keeps its result; input is taken while the last result of
// the previous request is being taken.
`include "assert_macros.svh"

module stream_find_and_replace #(
    parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF,
    parameter int COUNT_WIDTH = sfr_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // config write port
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_index,
    input  logic [63:0]                   cfg_data,
    // input requests
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    in_byte,
    input  logic                          stream_end,
    // output requests
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    out_byte,
    output logic                          byte_valid,
    output logic                          run_last,
    output logic                          output_end,
    output logic [sfr_pkg::SHOWN_W-1:0]   matches_seen
);

    // config registers
    logic [63:0]               pattern_bytes_reg;
    logic [sfr_pkg::LEN_W-1:0] pattern_length_reg;
    logic [63:0]               replacement_bytes_reg;
    logic [sfr_pkg::LEN_W-1:0] replacement_length_reg;

    // effective lengths after clamping
    logic [sfr_pkg::LEN_W-1:0] plen;
    logic [sfr_pkg::LEN_W-1:0] rlen;

    logic                      in_fire;
    logic                      out_fire;
    sfr_pkg::burst_load_t      load;

    // match counter, saturating
    logic [COUNT_WIDTH-1:0]    count_reg;
    logic [COUNT_WIDTH-1:0]    count_next;
    logic [31:0]               count_wide;
    logic [sfr_pkg::SHOWN_W-1:0] count_shown;

    // output buffer holding the results of one request
    logic [sfr_pkg::BURST_DEPTH-1:0][7:0] buf_bytes_reg;
    logic [sfr_pkg::BURST_DEPTH-1:0][7:0] buf_bytes_next;
    logic [sfr_pkg::BURST_CNT_W-1:0]      buf_cnt_reg;
    logic [sfr_pkg::BURST_CNT_W-1:0]      buf_cnt_next;
    logic                                 buf_bare_reg;
    logic                                 buf_bare_next;
    logic                                 buf_end_reg;
    logic                                 buf_end_next;
    logic [sfr_pkg::SHOWN_W-1:0]          buf_count_reg;
    logic [sfr_pkg::SHOWN_W-1:0]          buf_count_next;

    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            plen = sfr_pkg::LEN_W'(1);
        end
        else if (pattern_length_reg > sfr_pkg::LEN_W'(MAX_PATTERN))
        begin
            plen = sfr_pkg::LEN_W'(MAX_PATTERN);
        end
        else
        begin
            plen = pattern_length_reg;
        end
        if (replacement_length_reg > sfr_pkg::LEN_W'(sfr_pkg::REPL_MAX))
        begin
            rlen = sfr_pkg::LEN_W'(sfr_pkg::REPL_MAX);
        end
        else
        begin
            rlen = replacement_length_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg      <= '0;
            pattern_length_reg     <= sfr_pkg::LEN_W'(1);
            replacement_bytes_reg  <= '0;
            replacement_length_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (sfr_pkg::cfg_index_t'(cfg_index))
                sfr_pkg::CFG_PATTERN_BYTES: pattern_bytes_reg <= cfg_data;
                sfr_pkg::CFG_PATTERN_LEN:
                    pattern_length_reg <= cfg_data[sfr_pkg::LEN_W-1:0];
                sfr_pkg::CFG_REPL_BYTES:    replacement_bytes_reg <= cfg_data;
                sfr_pkg::CFG_REPL_LEN:
                    replacement_length_reg <= cfg_data[sfr_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // ready while the buffer is empty or its last result goes out now
    assign out_valid = (buf_cnt_reg != '0);
    assign out_fire  = out_valid && out_ready;
    assign in_ready  = (buf_cnt_reg == '0) ||
                       (buf_cnt_reg == sfr_pkg::BURST_CNT_W'(1) && out_ready);
    assign in_fire   = in_valid && in_ready;

    sfr_window #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (in_fire),
        .in_byte           (in_byte),
        .stream_end        (stream_end),
        .pattern_bytes     (pattern_bytes_reg),
        .plen              (plen),
        .replacement_bytes (replacement_bytes_reg),
        .rlen              (rlen),
        .load              (load)
    );

    always_comb
    begin
        count_next = count_reg;
        if (in_fire && load.hit && count_reg != {COUNT_WIDTH{1'b1}})
        begin
            count_next = count_reg + 1'b1;
        end
        // shown value is capped at the width of the result field
        count_wide  = 32'(count_next);
        count_shown = (count_wide > 32'h0000_FFFF) ? 16'hFFFF
                                                   : count_wide[sfr_pkg::SHOWN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        buf_bytes_next = buf_bytes_reg;
        buf_cnt_next   = buf_cnt_reg;
        buf_bare_next  = buf_bare_reg;
        buf_end_next   = buf_end_reg;
        buf_count_next = buf_count_reg;
        if (out_fire)
        begin
            for (int i = 0; i < sfr_pkg::BURST_DEPTH - 1; i++)
            begin
                buf_bytes_next[i] = buf_bytes_reg[i + 1];
            end
            buf_cnt_next = buf_cnt_reg - 1'b1;
        end
        // a new request only lands when the buffer is emptying
        if (in_fire && load.count != '0)
        begin
            buf_bytes_next = load.bytes;
            buf_cnt_next   = load.count;
            buf_bare_next  = load.bare;
            buf_end_next   = load.stream_end;
            buf_count_next = count_shown;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_cnt_reg <= '0;
        end
        else
        begin
            buf_cnt_reg <= buf_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_bytes_reg <= buf_bytes_next;
        buf_bare_reg  <= buf_bare_next;
        buf_end_reg   <= buf_end_next;
        buf_count_reg <= buf_count_next;
    end

    assign out_byte     = buf_bytes_reg[0];
    assign byte_valid   = !buf_bare_reg;
    assign run_last     = (buf_cnt_reg == sfr_pkg::BURST_CNT_W'(1));
    assign output_end   = run_last && buf_end_reg;
    assign matches_seen = buf_count_reg;

    // input is only taken with at most one result left in the buffer
    `SFR_ASSERT(a_ready_buf, clk, rst_n, in_ready |-> (buf_cnt_reg <= sfr_pkg::BURST_CNT_W'(1)))
    // buffer never holds more than one request can produce
    `SFR_ASSERT_NEVER(a_buf_depth, clk, rst_n,
        buf_cnt_reg > sfr_pkg::BURST_CNT_W'(sfr_pkg::BURST_DEPTH))
    // a bare end marker is always the single, final result
    `SFR_ASSERT(a_bare_end, clk, rst_n, (out_valid && !byte_valid) |-> (run_last && output_end))
    // with no request waiting, the buffer is empty after its last result goes out
    `SFR_ASSERT(a_drain, clk, rst_n,
        (out_fire && run_last && !in_valid) |=> (buf_cnt_reg == '0))

endmodule
